// File: design/websocket_frame_deframer_macros.svh
// Assertion macros for the websocket deframer modules; only wsd_parser uses them.
// Each file that asserts includes this header; it expects clk and rst in scope.
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`ifndef SYNTHESIS
`define WSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define WSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WSD_ASSERT_NOW(lbl, ante, cons, msg)
`define WSD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: design/wsd_pkg.sv
// Shared types and constants of the websocket frame deframer.
// Used by every module of the block; depends on nothing.
package wsd_pkg;

  // Largest message the block accepts, in bytes.
  localparam int unsigned MAX_MESSAGE = 65536;
  // Largest frame length that is not rejected as too long.
  localparam int unsigned LEN_LIMIT = (MAX_MESSAGE > 65535) ? MAX_MESSAGE : 65535;
  localparam int unsigned LEN_W     = $clog2(LEN_LIMIT + 1);
  localparam int unsigned MSG_W     = $clog2(MAX_MESSAGE + 1);
  localparam int unsigned SUM_W     = LEN_W + 1;

  // Parse phases.
  localparam logic [2:0] PH_HDR0    = 3'd0;
  localparam logic [2:0] PH_HDR1    = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_MASK    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  // Message in progress.
  localparam logic [1:0] MT_NONE = 2'd0;
  localparam logic [1:0] MT_TEXT = 2'd1;
  localparam logic [1:0] MT_BIN  = 2'd2;

  // Opcodes.
  localparam logic [3:0] OP_CONT       = 4'h0;
  localparam logic [3:0] OP_TEXT       = 4'h1;
  localparam logic [3:0] OP_BIN        = 4'h2;
  localparam logic [3:0] OP_DISCONNECT = 4'h8;
  localparam logic [3:0] OP_PING       = 4'h9;
  localparam logic [3:0] OP_PONG       = 4'hA;

  // Header field masks and length escapes.
  localparam logic [7:0] HDR_RSV_MASK = 8'h70;
  localparam logic [6:0] LEN_EXT16    = 7'd126;
  localparam logic [6:0] LEN_EXT64    = 7'd127;

  // Result kinds.
  localparam logic [2:0] KIND_TEXT  = 3'd0;
  localparam logic [2:0] KIND_PING  = 3'd1;
  localparam logic [2:0] KIND_CLOSE = 3'd2;
  localparam logic [2:0] KIND_PONG  = 3'd3;
  localparam logic [2:0] KIND_ERROR = 3'd4;

  // Error codes.
  localparam logic [1:0] ERR_RESERVED  = 2'd0;
  localparam logic [1:0] ERR_FRAME_LEN = 2'd1;
  localparam logic [1:0] ERR_ORPHAN    = 2'd2;
  localparam logic [1:0] ERR_MSG_LEN   = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic        has_byte;
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [15:0] close_code;
    logic [1:0]  error_code;
  } wsd_result_t;

endpackage

// File: design/websocket_frame_deframer.sv
// WebSocket receive deframer. It takes one received byte per item on the input
// channel and sustains one byte per clock cycle while results are read out: a byte
// enters an input register, the frame parser handles it once the result register is
// free, and any result it causes is registered in the result register and shown on
// the outputs from there, until the consumer takes it.
// The parser decodes the frame header (FIN, reserved bits, opcode, mask flag and
// 7-, 16- or 64-bit length), collects the optional 4-byte masking key, and unmasks
// the payload. Text payload bytes stream out with first_of_message on the first
// item of a new message and last on the end of the final frame; binary messages are
// tracked for length but dropped. Ping payload bytes are echoed for building a pong.
// Pong and close frames each give one item at the end of the frame, close with its
// status code. A protocol error gives one error item and then the block ignores all
// bytes until reset. The rate is limited only by the single parser pass per byte;
// a held byte waits while an unread result sits in the result register, and
// in_ready follows out_ready in the same cycle when both registers are full.
// Depends on wsd_pkg, wsd_in_stage, wsd_parser and wsd_out_stage.
module websocket_frame_deframer import wsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic        has_byte,
  output logic [7:0]  out_byte,
  output logic        first_of_message,
  output logic        last,
  output logic [15:0] close_code,
  output logic [1:0]  error_code
);

  logic        held_valid;
  logic [7:0]  held_byte;
  logic        free;
  logic        step;
  logic        res_valid;
  wsd_result_t res;
  wsd_result_t held;

  // The parser consumes the held byte whenever the result register can take
  // whatever that byte produces.
  assign step = held_valid && free;

  wsd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .take       (step),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  wsd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .rx_byte   (held_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  wsd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .res_valid (res_valid),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .free      (free),
    .held      (held)
  );

  assign out_kind         = held.kind;
  assign has_byte         = held.has_byte;
  assign out_byte         = held.data;
  assign first_of_message = held.first;
  assign last             = held.last;
  assign close_code       = held.close_code;
  assign error_code       = held.error_code;

endmodule

// File: design/wsd_in_stage.sv
// Input register of the websocket deframer: holds one received byte.
// Depends on wsd_pkg.
module wsd_in_stage import wsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  // A new item may enter when the register is empty or is drained this cycle.
  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= rx_byte;
    end
  end

endmodule

// File: design/wsd_parser.sv
// Frame parser of the websocket deframer: header decode, unmasking, message
// tracking and error detection, one byte per step. Depends on wsd_pkg and the macros.
`include "websocket_frame_deframer_macros.svh"
module wsd_parser import wsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  output wsd_result_t res
);

  logic [2:0]       phase, phase_next;
  logic             fin, fin_next;
  logic [3:0]       opcode, opcode_next;
  logic             masked, masked_next;
  logic [LEN_W-1:0] len_lo, len_lo_next;
  logic             len_hi, len_hi_next;
  logic [3:0]       aux_count, aux_count_next;
  logic [31:0]      mask_key, mask_key_next;
  logic [LEN_W-1:0] remaining, remaining_next;
  logic [1:0]       pidx, pidx_next;
  logic [MSG_W-1:0] msg_len, msg_len_next;
  logic [1:0]       msg_type, msg_type_next;
  logic             first_pending, first_pending_next;
  logic [15:0]      close_reg, close_reg_next;
  logic             halted, halted_next;

  logic             do_known, do_begin, do_event, ev_has, ev_end, begin_fail;
  logic [7:0]       ev_byte, key_byte;
  logic [LEN_W-1:0] len_val;
  logic [MSG_W-1:0] msg_base;
  logic [SUM_W-1:0] msg_sum;

  // Key byte for the current payload position, most significant byte first.
  always_comb begin
    case (pidx)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next         = phase;
    fin_next           = fin;
    opcode_next        = opcode;
    masked_next        = masked;
    len_lo_next        = len_lo;
    len_hi_next        = len_hi;
    aux_count_next     = aux_count;
    mask_key_next      = mask_key;
    remaining_next     = remaining;
    pidx_next          = pidx;
    msg_len_next       = msg_len;
    msg_type_next      = msg_type;
    first_pending_next = first_pending;
    close_reg_next     = close_reg;
    halted_next        = halted;
    res_valid          = 1'b0;
    res                = '0;
    do_known           = 1'b0;
    do_begin           = 1'b0;
    do_event           = 1'b0;
    ev_has             = 1'b0;
    ev_end             = 1'b0;
    ev_byte            = 8'd0;
    begin_fail         = 1'b0;
    len_val            = remaining;
    msg_base           = '0;
    msg_sum            = '0;

    if (step && !halted) begin
      unique case (phase)
        PH_HDR0: begin
          if (|(rx_byte & HDR_RSV_MASK)) begin
            halted_next    = 1'b1;
            res_valid      = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_RESERVED;
          end else begin
            fin_next    = rx_byte[7];
            opcode_next = rx_byte[3:0];
            phase_next  = PH_HDR1;
          end
        end
        PH_HDR1: begin
          masked_next = rx_byte[7];
          len_lo_next = '0;
          len_hi_next = 1'b0;
          if (rx_byte[6:0] == LEN_EXT16 || rx_byte[6:0] == LEN_EXT64) begin
            aux_count_next = (rx_byte[6:0] == LEN_EXT16) ? 4'd2 : 4'd8;
            phase_next     = PH_EXTLEN;
          end else begin
            len_val        = LEN_W'(rx_byte[6:0]);
            remaining_next = len_val;
            do_known       = 1'b1;
          end
        end
        PH_EXTLEN: begin
          // Bits shifted out of the kept window only matter as "too long".
          len_hi_next    = len_hi | (|len_lo[LEN_W-1:LEN_W-8]);
          len_lo_next    = {len_lo[LEN_W-9:0], rx_byte};
          aux_count_next = (aux_count != 4'd0) ? aux_count - 4'd1 : aux_count;
          if (aux_count_next == 4'd0) begin
            if (len_hi_next || len_lo_next > LEN_W'(LEN_LIMIT)) begin
              halted_next    = 1'b1;
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_FRAME_LEN;
            end else begin
              len_val        = len_lo_next;
              remaining_next = len_lo_next;
              do_known       = 1'b1;
            end
          end
        end
        PH_MASK: begin
          mask_key_next  = {mask_key[23:0], rx_byte};
          aux_count_next = (aux_count != 4'd0) ? aux_count - 4'd1 : aux_count;
          if (aux_count_next == 4'd0) begin
            do_begin = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          pidx_next      = pidx + 2'd1;
          remaining_next = (remaining != '0) ? remaining - LEN_W'(1) : remaining;
          do_event       = 1'b1;
          ev_has         = 1'b1;
          ev_byte        = rx_byte ^ key_byte;
          ev_end         = (remaining_next == '0);
        end
        default: begin
          phase_next = PH_HDR0;
        end
      endcase

      // Length complete: collect the key, or start the frame at once.
      if (do_known) begin
        mask_key_next = 32'd0;
        if (masked_next) begin
          phase_next     = PH_MASK;
          aux_count_next = 4'd4;
        end else begin
          do_begin = 1'b1;
        end
      end

      // Header complete: data frame checks, then start the payload.
      if (do_begin) begin
        if (opcode <= OP_BIN) begin
          if (opcode == OP_CONT && msg_type == MT_NONE) begin
            begin_fail     = 1'b1;
            res.error_code = ERR_ORPHAN;
          end else begin
            if (opcode != OP_CONT) begin
              msg_type_next      = (opcode == OP_TEXT) ? MT_TEXT : MT_BIN;
              first_pending_next = (opcode == OP_TEXT);
            end else begin
              msg_base = msg_len;
            end
            msg_sum = SUM_W'(msg_base) + SUM_W'(len_val);
            if (msg_sum > SUM_W'(MAX_MESSAGE)) begin
              begin_fail     = 1'b1;
              res.error_code = ERR_MSG_LEN;
            end else begin
              msg_len_next = msg_sum[MSG_W-1:0];
            end
          end
        end
        if (begin_fail) begin
          halted_next = 1'b1;
          res_valid   = 1'b1;
          res.kind    = KIND_ERROR;
        end else begin
          close_reg_next = 16'd0;
          aux_count_next = 4'd0;
          pidx_next      = 2'd0;
          if (len_val == '0) begin
            do_event = 1'b1;
            ev_end   = 1'b1;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end

      // One payload position, or the end of an empty frame.
      if (do_event) begin
        if (ev_end) begin
          phase_next = PH_HDR0;
        end
        if (opcode <= OP_BIN) begin
          if (msg_type_next == MT_TEXT && (ev_has || (ev_end && fin))) begin
            res_valid          = 1'b1;
            res.kind           = KIND_TEXT;
            res.has_byte       = ev_has;
            res.data           = ev_byte;
            res.first          = first_pending_next;
            res.last           = ev_end && fin;
            first_pending_next = 1'b0;
          end
          if (ev_end && fin) begin
            msg_type_next = MT_NONE;
          end
        end else if (opcode == OP_PING) begin
          if (ev_has || ev_end) begin
            res_valid    = 1'b1;
            res.kind     = KIND_PING;
            res.has_byte = ev_has;
            res.data     = ev_byte;
            res.last     = ev_end;
          end
        end else if (opcode == OP_DISCONNECT) begin
          // The first two payload bytes form the big-endian status code.
          if (ev_has && aux_count_next < 4'd2) begin
            close_reg_next = {close_reg_next[7:0], ev_byte};
            aux_count_next = aux_count_next + 4'd1;
          end
          if (ev_end) begin
            res_valid      = 1'b1;
            res.kind       = KIND_CLOSE;
            res.close_code = (aux_count_next >= 4'd2) ? close_reg_next : 16'd0;
          end
        end else if (opcode == OP_PONG) begin
          if (ev_end) begin
            res_valid = 1'b1;
            res.kind  = KIND_PONG;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HDR0;
      fin           <= 1'b0;
      opcode        <= OP_CONT;
      masked        <= 1'b0;
      len_lo        <= '0;
      len_hi        <= 1'b0;
      aux_count     <= 4'd0;
      mask_key      <= 32'd0;
      remaining     <= '0;
      pidx          <= 2'd0;
      msg_len       <= '0;
      msg_type      <= MT_NONE;
      first_pending <= 1'b0;
      close_reg     <= 16'd0;
      halted        <= 1'b0;
    end else begin
      phase         <= phase_next;
      fin           <= fin_next;
      opcode        <= opcode_next;
      masked        <= masked_next;
      len_lo        <= len_lo_next;
      len_hi        <= len_hi_next;
      aux_count     <= aux_count_next;
      mask_key      <= mask_key_next;
      remaining     <= remaining_next;
      pidx          <= pidx_next;
      msg_len       <= msg_len_next;
      msg_type      <= msg_type_next;
      first_pending <= first_pending_next;
      close_reg     <= close_reg_next;
      halted        <= halted_next;
    end
  end

  `WSD_ASSERT_NEXT(a_halt_sticks, halted, halted, "halted state left without reset")
  `WSD_ASSERT_NEXT(a_error_halts, res_valid && res.kind == KIND_ERROR, halted, "no halt")
  `WSD_ASSERT_NOW(a_payload_left, phase == PH_PAYLOAD, remaining != '0, "payload with none left")
  `WSD_ASSERT_NOW(a_msg_bound, 1'b1, msg_len <= MSG_W'(MAX_MESSAGE), "message above maximum")

endmodule

// File: design/wsd_out_stage.sv
// Result register of the websocket deframer: holds one result item for the consumer.
// Depends on wsd_pkg.
module wsd_out_stage import wsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic        res_valid,
  input  wsd_result_t res,
  input  logic        out_ready,
  output logic        out_valid,
  output logic        free,
  output wsd_result_t held
);

  // The register can take a new result when empty or being read out.
  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      held <= res;
    end
  end

endmodule

// File: dv/websocket_frame_deframer_test.sv
// Self-checking testbench for websocket_frame_deframer: drives framed byte streams and
// checks every result item against a cycle-free predictor of the frame parser.
// Depends on wsd_pkg and the websocket_frame_deframer RTL.
module websocket_frame_deframer_test;
  import wsd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Run control.
  localparam int unsigned CYCLE_LIMIT     = 2_000_000;
  localparam int unsigned RANDOM_BYTES    = 400;
  localparam int unsigned HOLD_OFF_CYCLES = 200;
  localparam int unsigned DRAIN_CYCLES    = 16;

  // How a frame header encodes its payload length.
  localparam int LENF_SHORT = 0;  // shortest encoding that fits
  localparam int LENF_16    = 1;  // 16-bit extended form when the value fits
  localparam int LENF_64    = 2;  // always the 64-bit extended form

  // Opcodes the block does not know; their payload is skipped silently.
  localparam logic [3:0] OP_RSVD_DATA_LO = 4'h3;
  localparam logic [3:0] OP_RSVD_DATA_HI = 4'h7;
  localparam logic [3:0] OP_RSVD_CTRL_LO = 4'hB;
  localparam logic [3:0] OP_RSVD_CTRL_HI = 4'hF;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_kind;
  logic        has_byte;
  logic [7:0]  out_byte;
  logic        first_of_message;
  logic        last;
  logic [15:0] close_code;
  logic [1:0]  error_code;

  websocket_frame_deframer DUT (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .rx_byte          (rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .has_byte         (has_byte),
    .out_byte         (out_byte),
    .first_of_message (first_of_message),
    .last             (last),
    .close_code       (close_code),
    .error_code       (error_code)
  );

  // Shared run state. The idle enables are cleared for the last part of the run, and
  // hold_off_req asks the receiver process for one long stall.
  bit          failed            = 1'b0;
  bit          sender_idle_en    = 1'b1;
  bit          receiver_stall_en = 1'b1;
  bit          hold_off_req      = 1'b0;
  int unsigned bytes_sent        = 0;
  int unsigned cycle_count       = 0;

  // Message tracking on the stimulus side, so that random traffic stays legal: a
  // continuation is only sent while a data message is open, and never pushes the
  // message above MAX_MESSAGE.
  bit          msg_open  = 1'b0;
  longint unsigned msg_total = 0;

  // ---------------------------------------------------------------------------------
  // Predictor of the frame parser. It sees each accepted byte once, in order, and
  // appends the result items that byte causes to expected_results.
  // ---------------------------------------------------------------------------------
  logic [2:0]  rx_phase    = PH_HDR0;
  logic        hdr_fin     = 1'b0;
  logic [3:0]  hdr_op      = OP_CONT;
  logic        hdr_masked  = 1'b0;
  logic [63:0] ext_len     = '0;
  logic [3:0]  byte_count  = '0;   // extended length / key bytes left, or close bytes seen
  logic [31:0] unmask_key  = '0;
  logic [63:0] bytes_left  = '0;
  logic [1:0]  key_idx     = '0;
  logic [63:0] msg_len     = '0;
  logic [1:0]  msg_kind    = MT_NONE;
  logic        first_due   = 1'b0;
  logic [15:0] close_acc   = '0;
  logic        halted_seen = 1'b0;

  wsd_result_t expected_results[$];

  function automatic void expect_result(logic [2:0] kind, logic has, logic [7:0] data,
                                        logic first, logic lst, logic [15:0] code,
                                        logic [1:0] err);
    wsd_result_t r;
    r.kind       = kind;
    r.has_byte   = has;
    r.data       = data;
    r.first      = first;
    r.last       = lst;
    r.close_code = code;
    r.error_code = err;
    expected_results.push_back(r);
  endfunction

  // Any protocol error gives one error item and then the parser ignores everything.
  function automatic void expect_error(logic [1:0] err);
    halted_seen = 1'b1;
    expect_result(KIND_ERROR, 1'b0, 8'h00, 1'b0, 1'b0, 16'h0000, err);
  endfunction

  // One payload position, or the end of an empty frame when has is low.
  function automatic void payload_step(logic has, logic [7:0] data, logic is_end);
    if (is_end)
      rx_phase = PH_HDR0;
    if (hdr_op <= OP_BIN) begin
      // Only text is passed on; binary bytes are dropped. An empty final text frame
      // still closes the message with a byte-less item.
      if (msg_kind == MT_TEXT && (has || (is_end && hdr_fin))) begin
        expect_result(KIND_TEXT, has, data, first_due, is_end & hdr_fin, 16'h0000,
                      ERR_RESERVED);
        first_due = 1'b0;
      end
      if (is_end && hdr_fin)
        msg_kind = MT_NONE;
    end else if (hdr_op == OP_PING) begin
      if (has || is_end)
        expect_result(KIND_PING, has, data, 1'b0, is_end, 16'h0000, ERR_RESERVED);
    end else if (hdr_op == OP_DISCONNECT) begin
      // The status code is the first two payload bytes, big-endian.
      if (has && byte_count < 2) begin
        close_acc  = {close_acc[7:0], data};
        byte_count = byte_count + 1'b1;
      end
      if (is_end)
        expect_result(KIND_CLOSE, 1'b0, 8'h00, 1'b0, 1'b0,
                      (byte_count >= 2) ? close_acc : 16'h0000, ERR_RESERVED);
    end else if (hdr_op == OP_PONG) begin
      if (is_end)
        expect_result(KIND_PONG, 1'b0, 8'h00, 1'b0, 1'b0, 16'h0000, ERR_RESERVED);
    end
  endfunction

  // Header complete: data frames are checked for an orphan continuation and for an
  // oversized message before any payload byte is taken.
  function automatic void begin_payload();
    if (hdr_op <= OP_BIN) begin
      if (hdr_op == OP_CONT) begin
        if (msg_kind == MT_NONE) begin
          expect_error(ERR_ORPHAN);
          return;
        end
      end else begin
        // A new start frame abandons whatever message was in progress.
        msg_len   = '0;
        msg_kind  = (hdr_op == OP_TEXT) ? MT_TEXT : MT_BIN;
        first_due = (hdr_op == OP_TEXT);
      end
      if (msg_len + bytes_left > 64'(MAX_MESSAGE)) begin
        expect_error(ERR_MSG_LEN);
        return;
      end
      msg_len = msg_len + bytes_left;
    end
    close_acc  = '0;
    byte_count = '0;
    key_idx    = '0;
    if (bytes_left == 0)
      payload_step(1'b0, 8'h00, 1'b1);
    else
      rx_phase = PH_PAYLOAD;
  endfunction

  function automatic void finish_length();
    unmask_key = '0;
    if (hdr_masked) begin
      rx_phase   = PH_MASK;
      byte_count = 4'd4;
    end else begin
      begin_payload();
    end
  endfunction

  function automatic void predict_byte(logic [7:0] b);
    int unsigned key_shift;
    logic [6:0]  len7;
    if (halted_seen)
      return;
    case (rx_phase)
      PH_HDR0: begin
        if ((b & HDR_RSV_MASK) != 0) begin
          expect_error(ERR_RESERVED);
        end else begin
          hdr_fin  = b[7];
          hdr_op   = b[3:0];
          rx_phase = PH_HDR1;
        end
      end
      PH_HDR1: begin
        len7       = b[6:0];
        hdr_masked = b[7];
        ext_len    = '0;
        if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
          byte_count = (len7 == LEN_EXT16) ? 4'd2 : 4'd8;
          rx_phase   = PH_EXTLEN;
        end else begin
          bytes_left = 64'(len7);
          finish_length();
        end
      end
      PH_EXTLEN: begin
        ext_len = {ext_len[55:0], b};
        if (byte_count != 0)
          byte_count = byte_count - 1'b1;
        if (byte_count == 0) begin
          // Only a 64-bit length can exceed the frame limit.
          if (ext_len > 64'(MAX_MESSAGE) && ext_len > 64'hFFFF) begin
            expect_error(ERR_FRAME_LEN);
          end else begin
            bytes_left = ext_len;
            finish_length();
          end
        end
      end
      PH_MASK: begin
        unmask_key = {unmask_key[23:0], b};
        if (byte_count != 0)
          byte_count = byte_count - 1'b1;
        if (byte_count == 0)
          begin_payload();
      end
      PH_PAYLOAD: begin
        // Key bytes are applied most significant first, cycling every four bytes.
        key_shift = 24 - 8 * key_idx;
        key_idx   = key_idx + 1'b1;
        if (bytes_left != 0)
          bytes_left = bytes_left - 1;
        payload_step(1'b1, b ^ unmask_key[key_shift +: 8], bytes_left == 0);
      end
      default: rx_phase = PH_HDR0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------------
  // Result checking.
  // ---------------------------------------------------------------------------------
  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      failed = 1'b1;
    end
  endfunction

  function automatic void check_result();
    wsd_result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: result item with none expected, kind %0d byte %0h",
               $time, out_kind, out_byte);
      failed = 1'b1;
      return;
    end
    want = expected_results.pop_front();
    compare_field("out_kind", 16'(want.kind), 16'(out_kind));
    compare_field("has_byte", 16'(want.has_byte), 16'(has_byte));
    compare_field("out_byte", 16'(want.data), 16'(out_byte));
    compare_field("first_of_message", 16'(want.first), 16'(first_of_message));
    compare_field("last", 16'(want.last), 16'(last));
    compare_field("close_code", want.close_code, close_code);
    compare_field("error_code", 16'(want.error_code), 16'(error_code));
  endfunction

  // Both channels are sampled at the clock edge, before any update of that edge lands,
  // so a byte accepted here is predicted before its result can possibly appear.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        predict_byte(rx_byte);
      if (out_valid && out_ready)
        check_result();
    end
  end

  // ---------------------------------------------------------------------------------
  // Clock, watchdog and receiver.
  // ---------------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles", $time, cycle_count);
    $display("status: fail");
    $finish;
  end

  // The receiver stalls in short random bursts, and once for a long stretch when asked,
  // so that the result register fills and the block has to hold off its input.
  initial begin
    out_ready = 1'b0;
    while (rst)
      @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (receiver_stall_en && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------------
  // Sender.
  // ---------------------------------------------------------------------------------

  // Offers one item and returns at the edge where it is accepted. Valid is only lowered
  // for an idle burst, never between two back-to-back items.
  task automatic send_byte(input logic [7:0] b);
    if (sender_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do
      @(posedge clk);
    while (!in_ready);
    bytes_sent++;
  endtask

  // Sends a frame header with a fresh random masking key when masked is set.
  task automatic send_header(input logic fin, input logic [3:0] op, input logic masked,
                             input logic [63:0] len, input int len_form);
    logic [31:0] key;
    key = $urandom;
    send_byte({fin, 3'b000, op});
    if (len_form == LENF_SHORT && len < 64'(LEN_EXT16)) begin
      send_byte({masked, len[6:0]});
    end else if (len_form != LENF_64 && len <= 64'hFFFF) begin
      send_byte({masked, LEN_EXT16});
      send_byte(len[15:8]);
      send_byte(len[7:0]);
    end else begin
      send_byte({masked, LEN_EXT64});
      for (int i = 7; i >= 0; i--)
        send_byte(len[8*i +: 8]);
    end
    if (masked)
      for (int i = 3; i >= 0; i--)
        send_byte(key[8*i +: 8]);
  endtask

  // A whole frame with random payload bytes.
  task automatic send_frame(input logic fin, input logic [3:0] op, input logic masked,
                            input logic [63:0] len, input int len_form);
    send_header(fin, op, masked, len, len_form);
    for (longint unsigned k = 0; k < len; k++)
      send_byte(8'($urandom));
  endtask

  // ---------------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------------

  // Hand-picked frames: every opcode, all length encodings and their edges, the empty
  // frame cases, fragmentation with control frames in between, and a start frame
  // that abandons a message in progress.
  task automatic test_directed_frames();
    // Text frames over the length encodings; the empty one must still end the message.
    send_frame(1'b1, OP_TEXT, 1'b0, 0, LENF_SHORT);
    send_frame(1'b1, OP_TEXT, 1'b1, 5, LENF_SHORT);
    send_frame(1'b1, OP_TEXT, 1'b1, 125, LENF_SHORT);
    send_frame(1'b1, OP_TEXT, 1'b0, 3, LENF_16);
    send_frame(1'b1, OP_TEXT, 1'b1, 2, LENF_64);
    send_frame(1'b1, OP_TEXT, 1'b0, 130, LENF_SHORT);

    // Fragmented text with control frames (FIN clear on one) in the middle, and an
    // empty continuation that is not the last.
    send_frame(1'b0, OP_TEXT, 1'b1, 3, LENF_SHORT);
    send_frame(1'b0, OP_PING, 1'b1, 2, LENF_SHORT);
    send_frame(1'b1, OP_DISCONNECT, 1'b0, 2, LENF_SHORT);
    send_frame(1'b0, OP_CONT, 1'b0, 0, LENF_SHORT);
    send_frame(1'b1, OP_PONG, 1'b1, 1, LENF_SHORT);
    send_frame(1'b1, OP_CONT, 1'b1, 4, LENF_SHORT);

    // A new text start abandons the open one; an empty final continuation ends one.
    send_frame(1'b0, OP_TEXT, 1'b0, 2, LENF_SHORT);
    send_frame(1'b1, OP_TEXT, 1'b1, 1, LENF_SHORT);
    send_frame(1'b0, OP_TEXT, 1'b0, 1, LENF_SHORT);
    send_frame(1'b1, OP_CONT, 1'b1, 0, LENF_SHORT);

    // Binary is tracked but dropped, also when it cuts off a text message.
    send_frame(1'b0, OP_BIN, 1'b1, 4, LENF_SHORT);
    send_frame(1'b1, OP_CONT, 1'b0, 3, LENF_SHORT);
    send_frame(1'b0, OP_TEXT, 1'b0, 2, LENF_SHORT);
    send_frame(1'b0, OP_BIN, 1'b0, 2, LENF_SHORT);
    send_frame(1'b1, OP_CONT, 1'b1, 2, LENF_SHORT);

    // Control frames: empty and full-size pings, empty and short pongs, close payloads
    // shorter than, equal to and longer than the status code, and a long ping.
    send_frame(1'b1, OP_PING, 1'b0, 0, LENF_SHORT);
    send_frame(1'b1, OP_PING, 1'b1, 125, LENF_SHORT);
    send_frame(1'b1, OP_PONG, 1'b0, 0, LENF_SHORT);
    send_frame(1'b1, OP_PONG, 1'b1, 6, LENF_16);
    for (int n = 0; n <= 3; n++)
      send_frame(1'b1, OP_DISCONNECT, n[0], 64'(n), LENF_SHORT);
    send_frame(1'b1, OP_DISCONNECT, 1'b1, 5, LENF_64);
    send_frame(1'b1, OP_PING, 1'b1, 200, LENF_64);

    // Unknown opcodes produce nothing, whatever their length.
    send_frame(1'b1, OP_RSVD_DATA_LO, 1'b0, 2, LENF_SHORT);
    send_frame(1'b0, OP_RSVD_DATA_HI, 1'b1, 5, LENF_SHORT);
    send_frame(1'b1, OP_RSVD_CTRL_LO, 1'b0, 0, LENF_SHORT);
    send_frame(1'b1, OP_RSVD_CTRL_HI, 1'b1, 4, LENF_16);
  endtask

  // The receiver stops for a long stretch while a long ping keeps arriving, so the
  // block fills up and must stall its input without losing an item.
  task automatic test_receiver_hold_off();
    hold_off_req = 1'b1;
    send_frame(1'b1, OP_PING, 1'b1, 240, LENF_16);
    send_frame(1'b1, OP_TEXT, 1'b0, 40, LENF_SHORT);
  endtask

  // Random legal frame sequences: mostly text and continuations, with binary, control
  // and unknown frames mixed in, random lengths, encodings, masks and payload.
  task automatic test_random_frames();
    int unsigned     start_count;
    int unsigned     pick;
    logic            fin;
    logic            masked;
    logic [3:0]      op;
    longint unsigned len;
    int              len_form;
    start_count = bytes_sent;
    while (bytes_sent - start_count < RANDOM_BYTES) begin
      pick   = $urandom_range(0, 15);
      fin    = 1'($urandom);
      masked = 1'($urandom);
      case ($urandom_range(0, 19))
        0, 1:            len = 0;
        16, 17, 18:      len = $urandom_range(120, 130);
        19:              len = $urandom_range(200, 300);
        default:         len = $urandom_range(1, 12);
      endcase
      case ($urandom_range(0, 9))
        0:       len_form = LENF_16;
        1:       len_form = LENF_64;
        default: len_form = LENF_SHORT;
      endcase
      case (pick)
        0, 1, 2, 3: op = OP_TEXT;
        4, 5, 6, 7: op = msg_open ? OP_CONT : OP_TEXT;
        8:          op = OP_BIN;
        9:          op = OP_PING;
        10:         op = OP_PONG;
        11:         op = OP_DISCONNECT;
        12:         op = $urandom_range(0, 1)
                         ? 4'($urandom_range(OP_RSVD_DATA_LO, OP_RSVD_DATA_HI))
                         : 4'($urandom_range(OP_RSVD_CTRL_LO, OP_RSVD_CTRL_HI));
        default:    op = OP_TEXT;
      endcase
      // Keep a continuation from pushing the message past the limit.
      if (op == OP_CONT && msg_total + len > MAX_MESSAGE)
        len = 0;
      send_frame(fin, op, masked, len, len_form);
      if (op <= OP_BIN) begin
        msg_total = (op == OP_CONT) ? msg_total + len : len;
        msg_open  = !fin;
      end
    end
  endtask

  // Ends the run on one protocol error, picked at random since the block then halts
  // for good. Bytes sent after it must be ignored without any result.
  task automatic test_protocol_error();
    logic [1:0]  err;
    logic [63:0] bad_len;
    err = 2'($urandom_range(0, 3));
    case (err)
      ERR_RESERVED: begin
        send_byte({1'($urandom), 3'($urandom_range(1, 7)), 4'($urandom)});
      end
      ERR_FRAME_LEN: begin
        // A 64-bit length with at least one bit set above the limit.
        bad_len = {32'($urandom), 32'($urandom)} | (64'd1 << $urandom_range(17, 63));
        send_header(1'($urandom), OP_BIN, 1'($urandom), bad_len, LENF_64);
      end
      ERR_ORPHAN: begin
        // Close any open message first, then send a continuation with nothing to
        // continue.
        send_frame(1'b1, OP_BIN, 1'b0, 0, LENF_SHORT);
        send_header(1'($urandom), OP_CONT, 1'($urandom), $urandom_range(0, 20), LENF_SHORT);
      end
      default: begin
        // One byte already in the message plus a frame of the maximum size.
        send_frame(1'b0, OP_TEXT, 1'($urandom), 1, LENF_SHORT);
        send_header(1'b1, OP_CONT, 1'($urandom), 64'(MAX_MESSAGE), LENF_64);
      end
    endcase
    repeat (24)
      send_byte(8'($urandom));
  endtask

  // ---------------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------------
  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    rx_byte  = 8'h00;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_frames();
    test_receiver_hold_off();
    test_random_frames();

    // No idling on either side for the last part of the run.
    sender_idle_en    = 1'b0;
    receiver_stall_en = 1'b0;
    test_protocol_error();
    in_valid <= 1'b0;

    // Wait out the results still in flight; the watchdog bounds this.
    while (expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (!failed)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/wsd_pkg.sv
design/wsd_in_stage.sv
design/wsd_parser.sv
design/wsd_out_stage.sv
design/websocket_frame_deframer.sv
dv/websocket_frame_deframer_test.sv
